[design/upjn_pkg.sv]
// Shared types and constants for the URL path normaliser.
// No dependencies; imported by every module of the block.
`default_nettype none

package upjn_pkg;

    localparam int PATH_LIMIT = 4096;
    localparam int DL_W = $clog2(PATH_LIMIT);
    localparam logic [DL_W:0] PATH_LIMIT_V = (DL_W + 1)'(PATH_LIMIT);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int ROOT_W = 12;
    localparam int SPACE_W = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SPACE = 2'd1;
    localparam logic [SPACE_W-1:0] OUTPUT_SPACE_RST = 13'd4096;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      byte_cnt;
        logic            last;
        t_status         status;
        logic            is_dir;
    } t_job;

endpackage

`default_nettype wire

[design/upjn_front.sv]
// Front end: configuration registers, percent decoding and segment classification.
// A job (bytes, end-of-path status) per item that emits or ends a path. Uses upjn_pkg.
`default_nettype none

module upjn_front
    import upjn_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_take,
    input  wire logic [7:0]            i_char_code,
    input  wire logic                  i_carries_char,
    input  wire logic                  i_end_of_path,
    output logic                       o_push,
    output t_job                       o_job
);

    typedef enum logic [2:0] {
        ESC_NONE = 3'b001,
        ESC_HIGH = 3'b010,
        ESC_LOW  = 3'b100
    } t_esc_phase;

    typedef enum logic [1:0] {
        SF_NONE     = 2'd0,
        SF_INVALID  = 2'd1,
        SF_TOO_LONG = 2'd2,
        SF_OVERFLOW = 2'd3
    } t_seg_fault;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        t_seg_fault      sf;
    } t_seg_end;

    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic t_seg_end end_seg(t_seg_fault sf, logic [1:0] len,
                                         logic [7:0] h0, logic [7:0] h1);
        t_seg_end r;
        r.bytes = '0;
        r.cnt = 3'd0;
        r.sf = sf;
        if (sf == SF_OVERFLOW) begin
            r.sf = SF_TOO_LONG;
        end else if (sf == SF_NONE) begin
            if (len == 2'd1) begin
                if (h0 != CH_DOT) begin
                    r.bytes[0] = CH_SLASH;
                    r.bytes[1] = h0;
                    r.cnt = 3'd2;
                end
            end else if (len == 2'd2) begin
                if (h0 == CH_DOT && h1 == CH_DOT) begin
                    r.sf = SF_INVALID;
                end else begin
                    r.bytes[0] = CH_SLASH;
                    r.bytes[1] = h0;
                    r.bytes[2] = h1;
                    r.cnt = 3'd3;
                end
            end
        end
        return r;
    endfunction

    logic [ROOT_W-1:0]  r_root;
    logic [SPACE_W-1:0] r_space;
    t_esc_phase         r_phase, n_phase;
    logic [3:0]         r_hi, n_hi;
    logic [7:0]         r_held0, n_held0;
    logic [7:0]         r_held1, n_held1;
    logic [1:0]         r_seglen, n_seglen;
    logic [SPACE_W-1:0] r_emitted, n_emitted;
    logic [DL_W-1:0]    r_declen, n_declen;
    logic               r_lws, n_lws;
    t_status            r_df, n_df;
    t_seg_fault         r_sf, n_sf;

    logic [4:0]      hex;
    logic            dec_ok;
    logic [7:0]      dec_byte;
    logic [DL_W:0]   declen_inc;
    logic [3:0][7:0] byte_list;
    logic [2:0]      byte_cnt;
    logic            byte_normal;
    t_seg_fault      sf_b;
    t_seg_end        es_slash;
    t_seg_end        es_fin;
    logic            last_go;
    t_status         df_fin;
    logic            fin_end;
    logic [3:0][7:0] list;
    logic [2:0]      cnt;
    t_seg_fault      sf_pre;
    logic [13:0]     base;
    logic [2:0]      fit_k;
    logic            ovf;
    t_status         status;

    assign hex = hex_val(i_char_code);
    assign declen_inc = {1'b0, r_declen} + 1'b1;
    assign base = {2'b00, r_root} + {1'b0, r_emitted};
    assign es_slash = end_seg(r_sf, r_seglen, r_held0, r_held1);
    assign es_fin = end_seg(sf_b, n_seglen, n_held0, n_held1);

    always_comb begin
        n_phase = r_phase;
        n_hi = r_hi;
        n_held0 = r_held0;
        n_held1 = r_held1;
        n_seglen = r_seglen;
        n_declen = r_declen;
        n_lws = r_lws;
        n_df = r_df;
        sf_b = r_sf;
        dec_ok = 1'b0;
        dec_byte = CH_NUL;
        byte_list = '0;
        byte_cnt = 3'd0;
        byte_normal = 1'b0;

        if (i_take && i_carries_char && r_df == ST_OK) begin
            unique case (r_phase)
                ESC_NONE: begin
                    if (i_char_code == CH_PERCENT) begin
                        n_phase = ESC_HIGH;
                    end else if (i_char_code == CH_NUL) begin
                        n_df = ST_INVALID;
                    end else begin
                        dec_ok = 1'b1;
                        dec_byte = i_char_code;
                    end
                end
                ESC_HIGH: begin
                    if (hex[4]) begin
                        n_hi = hex[3:0];
                        n_phase = ESC_LOW;
                    end else begin
                        n_df = ST_INVALID;
                    end
                end
                ESC_LOW: begin
                    if (hex[4]) begin
                        n_phase = ESC_NONE;
                        if ({r_hi, hex[3:0]} == CH_NUL) begin
                            n_df = ST_INVALID;
                        end else begin
                            dec_ok = 1'b1;
                            dec_byte = {r_hi, hex[3:0]};
                        end
                    end else begin
                        n_df = ST_INVALID;
                    end
                end
                default: n_df = ST_INVALID;
            endcase
        end

        if (dec_ok) begin
            if (declen_inc >= PATH_LIMIT_V) begin
                n_df = ST_TOO_LONG;
            end else begin
                n_declen = declen_inc[DL_W-1:0];
                n_lws = (dec_byte == CH_SLASH);
                if (r_sf == SF_NONE || r_sf == SF_OVERFLOW) begin
                    if (dec_byte == CH_SLASH) begin
                        byte_list = es_slash.bytes;
                        byte_cnt = es_slash.cnt;
                        sf_b = es_slash.sf;
                        n_seglen = 2'd0;
                        n_held0 = CH_NUL;
                        n_held1 = CH_NUL;
                    end else if (dec_byte < CH_CTRL_LIMIT) begin
                        sf_b = SF_INVALID;
                    end else begin
                        if (r_sf == SF_NONE) begin
                            unique case (r_seglen)
                                2'd0: n_held0 = dec_byte;
                                2'd1: n_held1 = dec_byte;
                                2'd2: begin
                                    byte_list[0] = CH_SLASH;
                                    byte_list[1] = r_held0;
                                    byte_list[2] = r_held1;
                                    byte_list[3] = dec_byte;
                                    byte_cnt = 3'd4;
                                    byte_normal = 1'b1;
                                end
                                default: begin
                                    byte_list[0] = dec_byte;
                                    byte_cnt = 3'd1;
                                    byte_normal = 1'b1;
                                end
                            endcase
                        end
                        if (r_seglen != 2'd3) n_seglen = r_seglen + 2'd1;
                    end
                end
            end
        end
    end

    // end of path: open escape, closing segment, shared fit check
    always_comb begin
        last_go = i_take && i_end_of_path;
        df_fin = n_df;
        if (n_df == ST_OK && n_phase != ESC_NONE) df_fin = ST_INVALID;
        fin_end = last_go && df_fin == ST_OK;

        if (byte_cnt != 3'd0) begin
            list = byte_list;
            cnt = byte_cnt;
        end else if (fin_end) begin
            list = es_fin.bytes;
            cnt = es_fin.cnt;
        end else begin
            list = '0;
            cnt = 3'd0;
        end
        sf_pre = fin_end ? es_fin.sf : sf_b;

        fit_k = 3'd0;
        for (int i = 1; i <= 4; i++) begin
            if (3'(i) <= cnt && (base + 14'(i)) < {1'b0, r_space}) fit_k = fit_k + 3'd1;
        end
        ovf = fit_k < cnt;

        n_sf = sf_pre;
        if (ovf) n_sf = (byte_normal && !fin_end) ? SF_OVERFLOW : SF_TOO_LONG;
        n_emitted = r_emitted + SPACE_W'(fit_k);

        if (df_fin != ST_OK) status = df_fin;
        else if ({1'b0, r_root} >= r_space) status = ST_TOO_LONG;
        else if (n_sf == SF_NONE) status = ST_OK;
        else if (n_sf == SF_INVALID) status = ST_INVALID;
        else status = ST_TOO_LONG;
    end

    assign o_push = i_take && (fit_k != 3'd0 || i_end_of_path);
    assign o_job.bytes = list;
    assign o_job.byte_cnt = fit_k;
    assign o_job.last = i_end_of_path;
    assign o_job.status = status;
    assign o_job.is_dir = (status == ST_OK) && (n_lws || n_emitted == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
            r_space <= OUTPUT_SPACE_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ROOT_LENGTH) r_root <= i_cfg_data[ROOT_W-1:0];
            else if (i_cfg_index == CFG_OUTPUT_SPACE) r_space <= i_cfg_data[SPACE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || last_go) begin
            r_phase <= ESC_NONE;
            r_hi <= '0;
            r_held0 <= '0;
            r_held1 <= '0;
            r_seglen <= '0;
            r_emitted <= '0;
            r_declen <= '0;
            r_lws <= 1'b0;
            r_df <= ST_OK;
            r_sf <= SF_NONE;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_hi <= n_hi;
            r_held0 <= n_held0;
            r_held1 <= n_held1;
            r_seglen <= n_seglen;
            r_emitted <= n_emitted;
            r_declen <= n_declen;
            r_lws <= n_lws;
            r_df <= n_df;
            r_sf <= n_sf;
        end
    end

endmodule

`default_nettype wire

[design/upjn_queue.sv]
// Short job queue between the front end and the result sequencer.
// Register-based circular buffer of t_job entries. Uses upjn_pkg.
`default_nettype none

module upjn_queue
    import upjn_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_push_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_job      o_head
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_push_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop) r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

endmodule

`default_nettype wire

[design/upjn_back.sv]
// Result sequencer: walks the head job into the output register, one result per cycle
// while i_ready allows. Depends on upjn_pkg and the head of upjn_queue.
`default_nettype none

module upjn_back
    import upjn_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  t_job      i_head,
    output logic      o_pop,
    input  wire logic i_ready,
    output logic      o_valid,
    output logic [7:0] o_out_byte,
    output logic      o_byte_valid,
    output logic      o_run_last,
    output logic [1:0] o_status,
    output logic      o_is_directory
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_bv;
    logic       r_last;
    t_status    r_status;
    logic       r_isdir;

    logic       load;
    logic [2:0] res_cnt;
    logic       is_end;
    logic       has_byte;

    assign load = !i_empty && (!r_valid || i_ready);
    assign res_cnt = (i_head.byte_cnt == 3'd0) ? 3'd1 : i_head.byte_cnt;
    assign is_end = ({1'b0, r_idx} == res_cnt - 3'd1);
    assign has_byte = {1'b0, r_idx} < i_head.byte_cnt;
    assign o_pop = load && is_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx <= is_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= has_byte ? i_head.bytes[r_idx] : CH_NUL;
            r_bv <= has_byte;
            r_last <= i_head.last && is_end;
            r_status <= (i_head.last && is_end) ? i_head.status : ST_OK;
            r_isdir <= i_head.last && is_end && i_head.is_dir;
        end
    end

    assign o_valid = r_valid;
    assign o_out_byte = r_byte;
    assign o_byte_valid = r_bv;
    assign o_run_last = r_last;
    assign o_status = r_status;
    assign o_is_directory = r_isdir;

endmodule

`default_nettype wire

[design/url_path_jail_normalizer_core.sv]
// Top level of the URL path normaliser: front end, job queue, result sequencer.
// Depends on upjn_pkg, upjn_front, upjn_queue and upjn_back.
//
//  channel   valid         ready         payload
//  -------   -----------   -----------   -------------------------------------------
//  input     i_valid       o_ready       i_char_code, i_carries_char, i_end_of_path
//  result    o_valid       i_ready       o_out_byte, o_byte_valid, o_run_last,
//                                        o_status, o_is_directory
//  config    i_cfg_valid   o_cfg_ready   i_cfg_index, i_cfg_data
//
// One item per cycle enters the front end while o_ready is high; each becomes a job
// of 1 to 4 results or none. Results leave one per cycle while i_ready is high.
// o_ready falls only while the four-entry job queue is full.
// Reset is synchronous: root length 0, output space 4096, all path state cleared.
`default_nettype none

module url_path_jail_normalizer_core
    import upjn_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [7:0]            i_char_code,
    input  wire logic                  i_carries_char,
    input  wire logic                  i_end_of_path,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [7:0]                 o_out_byte,
    output logic                       o_byte_valid,
    output logic                       o_run_last,
    output logic [1:0]                 o_status,
    output logic                       o_is_directory,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic take;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job push_job;
    t_job head;

    assign o_ready = !full;
    assign o_cfg_ready = 1'b1;
    assign take = i_valid && !full;

    upjn_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_take         (take),
        .i_char_code    (i_char_code),
        .i_carries_char (i_carries_char),
        .i_end_of_path  (i_end_of_path),
        .o_push         (push),
        .o_job          (push_job)
    );

    upjn_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_full     (full),
        .o_empty    (empty),
        .o_head     (head)
    );

    upjn_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head),
        .o_pop          (pop),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_run_last     (o_run_last),
        .o_status       (o_status),
        .o_is_directory (o_is_directory)
    );

endmodule

`default_nettype wire

[tb/tb_url_path_jail_normalizer_core.sv]
// Self-checking testbench for url_path_jail_normalizer_core: a directed table, then random
// paths over several register settings, each beat checked against a predictor or table row.
// Depends on upjn_pkg and the core RTL only.
module tb_url_path_jail_normalizer_core
    import upjn_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 50;
    localparam int SEG_SAT = 8191;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {ESC_NONE, ESC_HIGH, ESC_LOW} t_esc;
    typedef enum logic [1:0] {FLT_NONE, FLT_INVALID, FLT_TOO_LONG, FLT_OVERFLOW} t_fault;

    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
        t_status    status;
        logic       dir;
    } t_norm_result;

    typedef struct {
        logic [7:0] chr;
        logic       carries;
        logic       eop;
        logic       typed_in;
        t_status    status;
        logic       dir;
    } t_path_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [7:0]            i_char_code;
    logic                  i_carries_char;
    logic                  i_end_of_path;
    logic                  o_valid;
    logic                  i_ready;
    logic [7:0]            o_out_byte;
    logic                  o_byte_valid;
    logic                  o_run_last;
    logic [1:0]            o_status;
    logic                  o_is_directory;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // sideband travelling with the input beat: a typed-in expectation for the table rows
    logic    exp_tagged;
    t_status exp_tag_status;
    logic    exp_tag_dir;

    url_path_jail_normalizer_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_code    (i_char_code),
        .i_carries_char (i_carries_char),
        .i_end_of_path  (i_end_of_path),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_run_last     (o_run_last),
        .o_status       (o_status),
        .o_is_directory (o_is_directory),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // predictor state
    logic [ROOT_W-1:0]  cfg_root;
    logic [SPACE_W-1:0] cfg_space;
    t_esc               esc_phase;
    logic [3:0]         hi_nib;
    logic [7:0]         held [2];
    int                 seg_len;
    int                 emitted;
    int                 decoded;
    logic               last_slash;
    t_fault             dec_fault;
    t_fault             seg_fault;

    t_norm_result step_results[$];
    t_norm_result pending_results[$];
    logic [7:0]   path_q[$];

    int  mismatches;
    int  results_checked;
    int  items_sent;
    int  paths_sent;
    int  cfg_writes;
    int  cycles;
    int  rx_hold;
    bit  rx_stall_on;
    bit  tx_gap_on;

    t_path_row dir_rows[26] = '{
        // raw zero straight after reset
        '{CH_NUL,     1'b1, 1'b1, 1'b1, ST_INVALID, 1'b0},
        // empty path, byte ignored
        '{8'hFF,      1'b0, 1'b1, 1'b1, ST_OK,      1'b1},
        // escape still open at the end
        '{CH_PERCENT, 1'b1, 1'b0, 1'b0, ST_OK,      1'b0},
        '{"4",        1'b1, 1'b0, 1'b0, ST_OK,      1'b0},
        '{8'h00,      1'b0, 1'b1, 1'b1, ST_INVALID, 1'b0},
        // non-hex digit after the escape
        '{CH_PERCENT, 1'b1, 1'b0, 1'b0, ST_OK,      1'b0},
        '{"g",        1'b1, 1'b1, 1'b1, ST_INVALID, 1'b0},
        // dot-dot, half of it escaped
        '{CH_PERCENT, 1'b1, 1'b0, 1'b0, ST_OK,      1'b0},
        '{"2",        1'b1, 1'b0, 1'b0, ST_OK,      1'b0},
        '{"e",        1'b1, 1'b0, 1'b0, ST_OK,      1'b0},
        '{CH_DOT,     1'b1, 1'b1, 1'b1, ST_INVALID, 1'b0},
        // decoded zero
        '{CH_PERCENT, 1'b1, 1'b0, 1'b0, ST_OK,      1'b0},
        '{"0",        1'b1, 1'b0, 1'b0, ST_OK,      1'b0},
        '{"0",        1'b1, 1'b1, 1'b1, ST_INVALID, 1'b0},
        // two held bytes flushed by the slash, empty beat in between
        '{"A",        1'b1, 1'b0, 1'b0, ST_OK,      1'b0},
        '{8'h00,      1'b0, 1'b0, 1'b0, ST_OK,      1'b0},
        '{"b",        1'b1, 1'b0, 1'b0, ST_OK,      1'b0},
        '{CH_SLASH,   1'b1, 1'b1, 1'b0, ST_OK,      1'b0},
        // four beats from one item, then a control byte
        '{CH_PERCENT, 1'b1, 1'b0, 1'b0, ST_OK,      1'b0},
        '{"F",        1'b1, 1'b0, 1'b0, ST_OK,      1'b0},
        '{"f",        1'b1, 1'b0, 1'b0, ST_OK,      1'b0},
        '{"x",        1'b1, 1'b0, 1'b0, ST_OK,      1'b0},
        '{"y",        1'b1, 1'b0, 1'b0, ST_OK,      1'b0},
        '{8'h1F,      1'b1, 1'b1, 1'b0, ST_OK,      1'b0},
        // single dot segment dropped
        '{CH_DOT,     1'b1, 1'b0, 1'b0, ST_OK,      1'b0},
        '{CH_SLASH,   1'b1, 1'b1, 1'b1, ST_OK,      1'b1}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic int hex_val(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic void clear_path();
        esc_phase = ESC_NONE;
        hi_nib = 4'h0;
        held[0] = 8'h00;
        held[1] = 8'h00;
        seg_len = 0;
        emitted = 0;
        decoded = 0;
        last_slash = 1'b0;
        dec_fault = FLT_NONE;
        seg_fault = FLT_NONE;
    endfunction

    function automatic void push_beat(logic [7:0] d, logic v);
        t_norm_result r;
        r = '{d, v, 1'b0, ST_OK, 1'b0};
        if (step_results.size() < 4) step_results.push_back(r);
    endfunction

    function automatic void put_out(logic [7:0] b);
        if (seg_fault != FLT_NONE) return;
        if (int'(cfg_root) + emitted + 1 < int'(cfg_space)) begin
            push_beat(b, 1'b1);
            emitted++;
        end else begin
            seg_fault = FLT_OVERFLOW;
        end
    endfunction

    function automatic void close_segment();
        if (seg_fault == FLT_OVERFLOW) begin
            seg_fault = FLT_TOO_LONG;
        end else if (seg_fault == FLT_NONE) begin
            if (seg_len == 1) begin
                if (held[0] != CH_DOT) begin
                    put_out(CH_SLASH);
                    put_out(held[0]);
                end
            end else if (seg_len == 2) begin
                if (held[0] == CH_DOT && held[1] == CH_DOT) begin
                    seg_fault = FLT_INVALID;
                end else begin
                    put_out(CH_SLASH);
                    put_out(held[0]);
                    put_out(held[1]);
                end
            end
            if (seg_fault == FLT_OVERFLOW) seg_fault = FLT_TOO_LONG;
        end
        seg_len = 0;
        held[0] = 8'h00;
        held[1] = 8'h00;
    endfunction

    function automatic void segment_char(logic [7:0] d);
        last_slash = (d == CH_SLASH);
        if (seg_fault == FLT_INVALID || seg_fault == FLT_TOO_LONG) return;
        if (d == CH_SLASH) begin
            close_segment();
            return;
        end
        if (d < CH_CTRL_LIMIT) begin
            seg_fault = FLT_INVALID;
            return;
        end
        if (seg_fault == FLT_NONE) begin
            if (seg_len < 2) begin
                held[seg_len] = d;
            end else if (seg_len == 2) begin
                put_out(CH_SLASH);
                put_out(held[0]);
                put_out(held[1]);
                put_out(d);
            end else begin
                put_out(d);
            end
        end
        if (seg_len < SEG_SAT) seg_len++;
    endfunction

    function automatic void decoded_char(logic [7:0] d);
        if (decoded + 1 >= PATH_LIMIT) begin
            dec_fault = FLT_TOO_LONG;
            return;
        end
        decoded++;
        segment_char(d);
    endfunction

    function automatic void raw_char(logic [7:0] c);
        int h;
        logic [7:0] d;
        if (dec_fault != FLT_NONE) return;
        h = hex_val(c);
        case (esc_phase)
            ESC_NONE: begin
                if (c == CH_PERCENT) esc_phase = ESC_HIGH;
                else if (c == CH_NUL) dec_fault = FLT_INVALID;
                else decoded_char(c);
            end
            ESC_HIGH: begin
                if (h < 0) begin
                    dec_fault = FLT_INVALID;
                end else begin
                    hi_nib = h[3:0];
                    esc_phase = ESC_LOW;
                end
            end
            default: begin
                if (h < 0) begin
                    dec_fault = FLT_INVALID;
                end else begin
                    d = {hi_nib, h[3:0]};
                    esc_phase = ESC_NONE;
                    if (d == CH_NUL) dec_fault = FLT_INVALID;
                    else decoded_char(d);
                end
            end
        endcase
    endfunction

    function automatic void normalize_item(logic [7:0] c, logic carries, logic eop);
        t_status st;
        t_norm_result r;
        step_results.delete();
        if (carries) raw_char(c);
        if (!eop) return;
        if (dec_fault == FLT_NONE && esc_phase != ESC_NONE) dec_fault = FLT_INVALID;
        if (dec_fault == FLT_NONE) close_segment();
        if (dec_fault != FLT_NONE) st = t_status'(dec_fault);
        else if (cfg_root >= cfg_space) st = ST_TOO_LONG;
        else if (seg_fault == FLT_NONE) st = ST_OK;
        else if (seg_fault == FLT_INVALID) st = ST_INVALID;
        else st = ST_TOO_LONG;
        if (step_results.size() == 0) push_beat(8'h00, 1'b0);
        r = step_results.pop_back();
        r.last = 1'b1;
        r.status = st;
        r.dir = (st == ST_OK) && (last_slash || emitted == 0);
        step_results.push_back(r);
        clear_path();
    endfunction

    // ---------------- monitor and checker ----------------

    always @(posedge i_clk) begin
        t_norm_result want;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_ROOT_LENGTH) cfg_root = i_cfg_data[ROOT_W-1:0];
            else if (i_cfg_index == CFG_OUTPUT_SPACE) cfg_space = i_cfg_data;
        end
        if (i_rst_n && i_valid && o_ready) begin
            normalize_item(i_char_code, i_carries_char, i_end_of_path);
            if (exp_tagged) begin
                want = '{8'h00, 1'b0, 1'b1, exp_tag_status, exp_tag_dir};
                pending_results.push_back(want);
            end else begin
                foreach (step_results[j]) pending_results.push_back(step_results[j]);
            end
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: out_byte %02h last %0b",
                       o_out_byte, o_run_last);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %02h, got %02h", want.data, o_out_byte);
                    mismatches++;
                end
                if (o_byte_valid !== want.has_byte) begin
                    $error("byte_valid: expected %0b, got %0b", want.has_byte, o_byte_valid);
                    mismatches++;
                end
                if (o_run_last !== want.last) begin
                    $error("run_last: expected %0b, got %0b", want.last, o_run_last);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_is_directory !== want.dir) begin
                    $error("is_directory: expected %0b, got %0b", want.dir, o_is_directory);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d beats outstanding",
                     cycles, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------- idling ----------------

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(16, 40);
    endfunction

    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold--;
            i_ready <= 1'b0;
        end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
            rx_hold = idle_len() - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ---------------- drivers ----------------

    task automatic send_item(input logic [7:0] c, input logic carries, input logic eop,
                             input logic typed_in = 1'b0, input t_status st = ST_OK,
                             input logic dir = 1'b0);
        i_valid <= 1'b1;
        i_char_code <= c;
        i_carries_char <= carries;
        i_end_of_path <= eop;
        exp_tagged <= typed_in;
        exp_tag_status <= st;
        exp_tag_dir <= dir;
        do @(posedge i_clk); while (!o_ready);
        if (carries || eop) items_sent++;
        if (tx_gap_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat (idle_len()) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_writes++;
    endtask

    task automatic set_config(input int root, input int space);
        write_reg(CFG_ROOT_LENGTH, CFG_DATA_W'(root));
        write_reg(CFG_OUTPUT_SPACE, CFG_DATA_W'(space));
        if ($urandom_range(0, 1) != 0)
            write_reg($urandom_range(0, 1) != 0 ? CFG_SPARE_A : CFG_SPARE_B,
                      CFG_DATA_W'($urandom_range(0, 8191)));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ---------------- path generation ----------------

    function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
        if (n < 10) return "0" + n;
        return 8'((upper ? "A" : "a") + n - 10);
    endfunction

    function automatic void add_char(logic [7:0] d);
        if (d == CH_PERCENT || $urandom_range(0, 5) == 0) begin
            path_q.push_back(CH_PERCENT);
            path_q.push_back(hex_char(d[7:4], 1'($urandom_range(0, 1))));
            path_q.push_back(hex_char(d[3:0], 1'($urandom_range(0, 1))));
        end else begin
            path_q.push_back(d);
        end
    endfunction

    function automatic logic [7:0] seg_char();
        int r;
        logic [7:0] c;
        r = $urandom_range(0, 39);
        if (r < 4) return CH_DOT;
        if (r < 32) begin
            c = 8'($urandom_range(8'h21, 8'h7E));
            return (c == CH_SLASH) ? "_" : c;
        end
        if (r < 39) return 8'($urandom_range(8'h80, 8'hFF));
        return 8'($urandom_range(8'h01, 8'h1F));
    endfunction

    function automatic void build_clean_path();
        int nseg;
        int kind;
        nseg = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
        path_q.delete();
        if ($urandom_range(0, 1) != 0) add_char(CH_SLASH);
        for (int s = 0; s < nseg; s++) begin
            kind = $urandom_range(0, 19);
            if (s > 0) add_char(CH_SLASH);
            if (kind == 0) begin
                add_char(CH_DOT);
                add_char(CH_DOT);
            end else if (kind < 3) begin
                add_char(CH_DOT);
            end else if (kind > 3) begin
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4))
                    add_char(seg_char());
            end
        end
        if ($urandom_range(0, 2) == 0) add_char(CH_SLASH);
    endfunction

    function automatic void corrupt_path();
        int pos;
        pos = (path_q.size() == 0) ? 0 : $urandom_range(0, path_q.size() - 1);
        case ($urandom_range(0, 2))
            0: begin
                if (path_q.size() == 0) path_q.push_back(8'($urandom_range(0, 255)));
                else path_q[pos] = 8'($urandom_range(0, 255));
            end
            1: begin
                path_q.push_back(CH_PERCENT);
                if ($urandom_range(0, 1) != 0) path_q.push_back(hex_char(4'($urandom), 1'b1));
            end
            default: path_q.insert(pos, CH_NUL);
        endcase
    endfunction

    function automatic void build_noise_path();
        int r;
        path_q.delete();
        repeat ($urandom_range(1, 12)) begin
            r = $urandom_range(0, 9);
            if (r == 0) path_q.push_back(CH_PERCENT);
            else if (r == 1) path_q.push_back(CH_SLASH);
            else if (r == 2) path_q.push_back(CH_DOT);
            else path_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_path();
        bit close_item;
        close_item = (path_q.size() == 0) || ($urandom_range(0, 3) == 0);
        foreach (path_q[i]) begin
            if ($urandom_range(0, 15) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(path_q[i], 1'b1, (i == path_q.size() - 1) && !close_item);
        end
        if (close_item) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        paths_sent++;
    endtask

    task automatic send_random_path();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8) build_clean_path();
        else build_noise_path();
        if (r == 7) corrupt_path();
        send_path();
    endtask

    // ---------------- sequence ----------------

    int phase_root[PHASES]  = '{0,    4095, 3,  0, 4095, 10, 0, 0};
    int phase_space[PHASES] = '{8191, 1,    12, 0, 4096, 16, 2, 0};

    initial begin
        int base;
        int root;
        int space;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_char_code <= 8'h00;
        i_carries_char <= 1'b0;
        i_end_of_path <= 1'b0;
        i_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_ROOT_LENGTH;
        i_cfg_data <= '0;
        exp_tagged <= 1'b0;
        exp_tag_status <= ST_OK;
        exp_tag_dir <= 1'b0;
        cfg_root = '0;
        cfg_space = OUTPUT_SPACE_RST;
        clear_path();
        rx_hold = 0;
        rx_stall_on = 1'b1;
        tx_gap_on = 1'b1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_item(dir_rows[k].chr, dir_rows[k].carries, dir_rows[k].eop,
                      dir_rows[k].typed_in, dir_rows[k].status, dir_rows[k].dir);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            root = phase_root[p];
            space = phase_space[p];
            if (p == PHASES - 1) begin
                root = $urandom_range(0, 30);
                space = root + $urandom_range(1, 60);
            end
            set_config(root, space);
            tx_gap_on = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            base = items_sent;
            while (items_sent - base < PHASE_ITEMS) send_random_path();
            drain();
        end

        $display("%0d path items over %0d paths, %0d result beats checked, %0d mismatches",
                 items_sent, paths_sent, results_checked, mismatches);
        $display("%0d register writes: reset, extreme, overflowing and random settings",
                 cfg_writes);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
design/upjn_pkg.sv
design/upjn_front.sv
design/upjn_queue.sv
design/upjn_back.sv
design/url_path_jail_normalizer_core.sv
tb/tb_url_path_jail_normalizer_core.sv
